FILE: rtl/rle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, sizes and codes of the rotating list engine.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [CNT_W-1:0]     pos;
    logic [CNT_W-1:0]     last;
    logic                 nonempty;
    logic [DATA_BITS-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        at_end;
    logic [4:0]  position;
  } rle_in_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } rle_out_t;

endpackage
`default_nettype wire

FILE: rtl/rle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_cell
// One slot of the list: holds a value, shifts from either neighbor, loads the
// new value or the front value, and feeds the back and removed-value OR chains.
// ----------------------------------------------------------------------------
module rle_cell (
  input  wire                          clk,
  input  wire  [rle_pkg::IDX_W-1:0]    idx,
  input  wire  rle_pkg::cell_ctl_t     ctl,
  input  wire  [rle_pkg::DATA_BITS-1:0] left_data,
  input  wire  [rle_pkg::DATA_BITS-1:0] right_data,
  input  wire  [rle_pkg::DATA_BITS-1:0] front_data,
  input  wire  [rle_pkg::DATA_BITS-1:0] back_in,
  input  wire  [rle_pkg::DATA_BITS-1:0] taken_in,
  output logic [rle_pkg::DATA_BITS-1:0] data,
  output logic [rle_pkg::DATA_BITS-1:0] back_out,
  output logic [rle_pkg::DATA_BITS-1:0] taken_out
);
  import rle_pkg::*;

  logic [DATA_BITS-1:0] data_r;
  logic [DATA_BITS-1:0] data_nxt;
  logic [CNT_W-1:0]     my_idx;

  assign my_idx = CNT_W'(idx);
  assign data   = data_r;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INSERT: begin
        if (my_idx > ctl.pos) begin
          data_nxt = left_data;
        end else if (my_idx == ctl.pos) begin
          data_nxt = ctl.value;
        end
      end
      OP_REMOVE: begin
        if (my_idx >= ctl.pos) begin
          data_nxt = right_data;
        end
      end
      OP_ROTATE: begin
        if (my_idx == ctl.last) begin
          data_nxt = front_data;
        end else if (my_idx < ctl.last) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  assign back_out  = back_in | ((ctl.nonempty && my_idx == ctl.last) ? data_r : '0);
  assign taken_out = taken_in | ((ctl.op == OP_REMOVE && my_idx == ctl.pos) ? data_r : '0);

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/rotating_list_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotating_list_engine_top
// Circular list of up to CAPACITY values with positional insert and remove,
// and rotate by one, built as a chain of cells.
// ----------------------------------------------------------------------------
// The cell chain updates at the edge that accepts the command, and front,
// back and count are gathered from the chain in the following cycle, which
// holds busy high. The result is registered at the end of that cycle and
// appears on out_result for exactly one cycle with out_valid high; the
// receiver cannot stall it, so a new command may start while the previous
// result is on the ports. Exactly one result per command.
module rotating_list_engine_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  rle_pkg::rle_in_t  in_item,
  output logic               out_valid,
  output rle_pkg::rle_out_t  out_result
);
  import rle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REPORT = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [DATA_BITS-1:0] taken_r;
  logic [1:0]           status_r, status_nxt;
  logic                 out_valid_r;
  rle_out_t             out_result_r;

  logic                 accept;
  logic [CNT_W-1:0]     in_pos;
  logic [CNT_W-1:0]     pos_eff;
  cell_op_t             op;
  cell_ctl_t            ctl;

  logic [DATA_BITS-1:0] cell_data [CAPACITY];
  logic [DATA_BITS-1:0] back_chain [CAPACITY+1];
  logic [DATA_BITS-1:0] taken_chain [CAPACITY+1];

  assign busy   = (state_r == ST_REPORT);
  assign accept = start && !busy;
  assign in_pos = CNT_W'(in_item.position);

  always_comb begin
    op         = OP_HOLD;
    status_nxt = STATUS_OK;
    count_nxt  = count_r;
    pos_eff    = in_pos;
    case (in_item.kind)
      KIND_INSERT: begin
        pos_eff = in_item.at_end ? count_r : in_pos;
        if (pos_eff > count_r) begin
          status_nxt = STATUS_BAD;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = STATUS_FULL;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        pos_eff = in_item.at_end ? (count_r - 1'b1) : in_pos;
        if (count_r == '0 || pos_eff >= count_r) begin
          status_nxt = STATUS_BAD;
        end else begin
          op        = OP_REMOVE;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_ADVANCE: begin
        if (count_r > CNT_W'(1)) begin
          op = OP_ROTATE;
        end
      end
      default: status_nxt = STATUS_BAD;
    endcase
    if (!accept) begin
      op = OP_HOLD;
    end
  end

  always_comb begin
    ctl.op       = op;
    ctl.pos      = pos_eff;
    ctl.last     = count_r - 1'b1;
    ctl.nonempty = (count_r != '0);
    ctl.value    = DATA_BITS'(in_item.value);
  end

  assign back_chain[0]  = '0;
  assign taken_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_BITS-1:0] left_w;
    logic [DATA_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    rle_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .left_data  (left_w),
      .right_data (right_w),
      .front_data (cell_data[0]),
      .back_in    (back_chain[i]),
      .taken_in   (taken_chain[i]),
      .data       (cell_data[i]),
      .back_out   (back_chain[i+1]),
      .taken_out  (taken_chain[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r  <= (op == OP_REMOVE) ? taken_chain[CAPACITY] : '0;
      status_r <= status_nxt;
    end
    if (busy) begin
      out_result_r.removed_value <= 32'(taken_r);
      out_result_r.front_value   <= (count_r != '0) ? 32'(cell_data[0]) : 32'd0;
      out_result_r.back_value    <= 32'(back_chain[CAPACITY]);
      out_result_r.entry_count   <= 5'(count_r);
      out_result_r.status        <= status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

FILE: dv/tb_rotating_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotating_list_engine_top
// Drives list commands into the rotating list engine and checks each result
// against an in-bench list predictor. A directed table covers the empty and
// full edges, every command kind and the error codes, then a random section
// drifts the fill level between drain-heavy and fill-heavy phases.
// ----------------------------------------------------------------------------
module tb_rotating_list_engine_top;
  import rle_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int N_RANDOM   = 1700;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    rle_in_t  item;
    int       reps;
    bit       has_exp;
    rle_out_t exp;
  } dir_row_t;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  rle_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  rle_out_t out_result;

  logic [DATA_BITS-1:0] list_mem [CAPACITY];
  int                   list_len = 0;
  rle_out_t             exp_q [$];
  int                   err_cnt = 0;
  int                   burst_left = 0;
  dir_row_t             dir_rows [$];

  rotating_list_engine_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rle_out_t list_step(input rle_in_t it);
    rle_out_t             res;
    int                   pos;
    int                   i;
    logic [DATA_BITS-1:0] first;
    res = '0;
    pos = it.position;
    case (it.kind)
      KIND_INSERT: begin
        if (it.at_end) pos = list_len;
        if (pos > list_len) begin
          res.status = STATUS_BAD;
        end else if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = it.value[DATA_BITS-1:0];
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (list_len == 0) begin
          res.status = STATUS_BAD;
        end else begin
          if (it.at_end) pos = list_len - 1;
          if (pos >= list_len) begin
            res.status = STATUS_BAD;
          end else begin
            res.removed_value = 32'(list_mem[pos]);
            for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
      end
      KIND_ADVANCE: begin
        if (list_len > 1) begin
          first = list_mem[0];
          for (i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_mem[list_len-1] = first;
        end
      end
      default: begin
        res.status = STATUS_BAD;
      end
    endcase
    res.front_value = (list_len == 0) ? 32'h0 : 32'(list_mem[0]);
    res.back_value  = (list_len == 0) ? 32'h0 : 32'(list_mem[list_len-1]);
    res.entry_count = 5'(list_len);
    return res;
  endfunction

  function automatic rle_in_t mk_cmd(input logic [1:0] kind, input logic [31:0] value,
                                     input logic at_end, input logic [4:0] position);
    rle_in_t it;
    it.kind     = kind;
    it.value    = value;
    it.at_end   = at_end;
    it.position = position;
    return it;
  endfunction

  task automatic add_row(input rle_in_t it, input int reps, input bit has_exp,
                         input rle_out_t exp);
    dir_row_t row;
    row.item    = it;
    row.reps    = reps;
    row.has_exp = has_exp;
    row.exp     = exp;
    dir_rows.push_back(row);
  endtask

  // hold the command until the transfer, then record what it should return
  task automatic send_cmd(input rle_in_t it, input bit has_exp, input rle_out_t typed);
    rle_out_t pred;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = list_step(it);
    exp_q.push_back(has_exp ? typed : pred);
  endtask

  // sender bursts: drop start for a random gap when a burst runs out
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 20);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      if (err_cnt < 10)
        $display("mismatch on %s at %0t: expected %h, got %h", name, $realtime, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rle_out_t want;
    if (rst_n && out_valid) begin
      if (exp_q.size() == 0) begin
        if (err_cnt < 10) $display("unexpected result at %0t: %h", $realtime, out_result);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        check_field("removed_value", want.removed_value, out_result.removed_value);
        check_field("front_value", want.front_value, out_result.front_value);
        check_field("back_value", want.back_value, out_result.back_value);
        check_field("entry_count", 32'(want.entry_count), 32'(out_result.entry_count));
        check_field("status", 32'(want.status), 32'(out_result.status));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rle_in_t  it;
    rle_out_t none;
    int       n;
    int       r;
    int       fill_bias;
    int       ins_pct;
    int       sel;

    none = '0;
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b1, 5'd0), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_BAD});
    add_row(mk_cmd(KIND_ADVANCE, 32'h0, 1'b0, 5'd0), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_OK});
    add_row(mk_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 5'd31), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_BAD});
    add_row(mk_cmd(KIND_INSERT, 32'h1111_1111, 1'b0, 5'd1), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_BAD});
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b0, 5'd0), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_BAD});
    add_row(mk_cmd(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, 5'd0), 1, 1'b1,
            rle_out_t'{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, STATUS_OK});
    add_row(mk_cmd(KIND_INSERT, 32'h0, 1'b1, 5'd31), 1, 1'b1,
            rle_out_t'{32'h0, 32'hFFFF_FFFF, 32'h0, 5'd2, STATUS_OK});
    add_row(mk_cmd(KIND_INSERT, 32'h1234_5678, 1'b0, 5'd2), 1, 1'b1,
            rle_out_t'{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 5'd3, STATUS_OK});
    add_row(mk_cmd(KIND_INSERT, 32'hA5A5_A5A5, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'h0000_0001, 1'b0, 5'd31), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'h5A5A_5A5A, 1'b0, 5'd5), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'h8000_0000, 1'b0, 5'd1), 1, 1'b0, none);
    add_row(mk_cmd(KIND_ADVANCE, 32'h0, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'h0001_0000, 1'b1, 5'd0), 11, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'hDEAD_BEEF, 1'b1, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'hDEAD_BEEF, 1'b0, 5'd17), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'hDEAD_BEEF, 1'b0, 5'd16), 1, 1'b0, none);
    add_row(mk_cmd(KIND_INSERT, 32'hDEAD_BEEF, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_ADVANCE, 32'h0, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b0, 5'd16), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b0, 5'd31), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b0, 5'd15), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b1, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_UNUSED, 32'h0, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b1, 5'd0), 13, 1'b0, none);
    add_row(mk_cmd(KIND_REMOVE, 32'h0, 1'b1, 5'd0), 1, 1'b1,
            rle_out_t'{32'h0, 32'h0, 32'h0, 5'd0, STATUS_BAD});
    add_row(mk_cmd(KIND_INSERT, 32'h0000_0007, 1'b0, 5'd0), 1, 1'b0, none);
    add_row(mk_cmd(KIND_ADVANCE, 32'h0, 1'b0, 5'd0), 1, 1'b0, none);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      for (r = 0; r < dir_rows[k].reps; r++) begin
        it = dir_rows[k].item;
        it.value = it.value + 32'(r);
        pace();
        send_cmd(it, dir_rows[k].has_exp, dir_rows[k].exp);
      end
    end

    fill_bias = 1;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 120 == 0) fill_bias = $urandom_range(0, 2);
      ins_pct = (fill_bias == 2) ? 70 : (fill_bias == 1) ? 45 : 25;
      sel = $urandom_range(0, 99);
      it.value = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)
                                             : $urandom();
      it.at_end = ($urandom_range(0, 3) == 0);
      it.position = 5'($urandom_range(0, 31));
      if (sel < ins_pct) begin
        it.kind = KIND_INSERT;
        if ($urandom_range(0, 9) != 0) it.position = 5'($urandom_range(0, list_len));
      end else if (sel < 90) begin
        it.kind = KIND_REMOVE;
        if ($urandom_range(0, 9) != 0 && list_len > 0)
          it.position = 5'($urandom_range(0, list_len - 1));
      end else if (sel < 98) begin
        it.kind = KIND_ADVANCE;
      end else begin
        it.kind = KIND_UNUSED;
      end
      pace();
      send_cmd(it, 1'b0, none);
    end

    start <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rle_pkg.sv
rtl/rle_cell.sv
rtl/rotating_list_engine_top.sv
dv/tb_rotating_list_engine_top.sv
